FILE: hw/rtl/rms_pkg.sv
// Package for the rate-monotonic task scheduler.
// Holds the table depth, word types, codes and constants; no dependencies.
package rms_pkg;
  localparam int MaxTasks = 16;
  localparam int SlotW = $clog2(MaxTasks);

  localparam logic [1:0] MODE_REG = 2'd0;
  localparam logic [1:0] MODE_YIELD = 2'd1;
  localparam logic [1:0] MODE_DEREG = 2'd2;
  localparam logic [1:0] MODE_TICK = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_DUP = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_OVER = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  localparam logic [1:0] RS_RUNNING = 2'd0;
  localparam logic [1:0] RS_READY = 2'd1;
  localparam logic [1:0] RS_SLEEPING = 2'd2;

  localparam logic [9:0] THRESH_RESET = 10'd693;
  localparam logic [9:0] SHARE_SCALE = 10'd1000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [21:0] task_id;
    logic [19:0] task_period;
    logic [19:0] compute_ms;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        running_valid;
    logic [21:0] running_task_id;
    logic        preempted_valid;
    logic [21:0] preempted_task_id;
    logic [14:0] total_share;
  } out_word_t;

  typedef struct packed {
    logic        start;
    logic [29:0] dividend;
    logic [19:0] divisor;
  } div_req_t;
endpackage

FILE: hw/rtl/rms_divider.sv
// Restoring divider, one quotient bit per cycle, for the share calculation.
// Depends on rms_pkg.
module rms_divider (
  input  logic              clk,
  input  logic              rst_n,
  input  rms_pkg::div_req_t req,
  output logic              done,
  output logic [9:0]        quotient
);
  logic [29:0] rem_r, rem_nxt;
  logic [29:0] quo_r, quo_nxt;
  logic [19:0] dsr_r, dsr_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [29:0] trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dsr_nxt = dsr_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[28:0], quo_r[29]};
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dsr_nxt = req.divisor;
      cnt_nxt = 5'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {10'd0, dsr_r}) begin
        rem_nxt = trial - {10'd0, dsr_r};
        quo_nxt = {quo_r[28:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[28:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd29) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done = done_r;
  // Share never exceeds 1000, so ten bits hold it.
  assign quotient = quo_r[9:0];
endmodule

FILE: hw/rtl/rate_monotonic_task_scheduler_top.sv
// Rate-monotonic task scheduler: task table, admission and dispatcher.
// Depends on rms_pkg and rms_divider.
// Every command walks the slot table one slot per cycle.
// After the find scan, register divides and sums shares; tick scans timers; tick and good yield
// then scan for the best task and dispatch. The result strobes in the first idle cycle after.
// Synchronous active-low reset clears the used bits, current task and clock, and reloads the threshold.
module rate_monotonic_task_scheduler_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rms_pkg::in_word_t  in_word,
  output logic               out_strobe,
  output rms_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [9:0]         cfg_wdata
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_FIND  = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_CMD   = 9'b000010000,
    S_TIMER = 9'b000100000,
    S_BEST  = 9'b001000000,
    S_DISP  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam int SW = rms_pkg::SlotW;
  localparam int NT = rms_pkg::MaxTasks;

  state_t state_r, state_nxt;
  logic [9:0]  thresh_r;
  logic [NT-1:0] used_r;
  logic [21:0] tid_r [NT];
  logic [19:0] per_r [NT];
  logic [9:0]  share_r [NT];
  logic [1:0]  rs_r [NT];
  logic [NT-1:0] rset_r, armed_r;
  logic [31:0] rel_r [NT];
  logic        cur_v_r;
  logic [SW-1:0] cur_r;
  logic [31:0] now_r;

  rms_pkg::in_word_t cmd_r;
  logic [SW-1:0] idx_r;
  logic        hit_r, free_v_r, best_v_r, fired_r, pre_v_r;
  logic [SW-1:0] hit_s_r, free_s_r, best_s_r;
  logic [14:0] total_r;
  logic [9:0]  share_new_r;
  logic [2:0]  status_r;
  logic [21:0] pre_id_r;
  logic        strobe_r, strobe_nxt;
  logic        yield_ok;
  rms_pkg::out_word_t out_r;

  rms_pkg::div_req_t dreq;
  logic        ddone;
  logic [9:0]  dq;

  rms_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quotient(dq));

  logic [SW-1:0] ix;
  logic          last;
  logic [31:0]   diff;
  assign ix = idx_r;
  assign last = (idx_r == SW'(NT - 1));
  assign diff = now_r - rel_r[ix];
  assign busy = (state_r != S_IDLE);

  // A successful yield leaves S_CMD toward the dispatch scan.
  assign yield_ok = (cmd_r.mode == rms_pkg::MODE_YIELD) && (cmd_r.task_id != '0) && hit_r &&
                    (rs_r[hit_s_r] == rms_pkg::RS_RUNNING ||
                     rs_r[hit_s_r] == rms_pkg::RS_SLEEPING);
  assign strobe_nxt = ((state_r == S_CMD) && !yield_ok) || (state_r == S_DISP);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (start) state_nxt = S_FIND;
      S_FIND: begin
        if (last) begin
          unique case (cmd_r.mode)
            rms_pkg::MODE_REG: state_nxt = S_DIV;
            rms_pkg::MODE_TICK: state_nxt = S_TIMER;
            default: state_nxt = S_CMD;
          endcase
        end
      end
      S_DIV:   if (ddone) state_nxt = S_SUM;
      S_SUM:   if (last) state_nxt = S_CMD;
      S_CMD:   state_nxt = yield_ok ? S_BEST : S_DONE;
      S_TIMER: if (last) state_nxt = S_BEST;
      S_BEST:  if (last) state_nxt = S_DISP;
      S_DISP:  state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    dreq.start = (state_r == S_FIND) && last && (cmd_r.mode == rms_pkg::MODE_REG);
    dreq.dividend = 30'(cmd_r.compute_ms) * 30'(rms_pkg::SHARE_SCALE);
    dreq.divisor = cmd_r.task_period;
  end

  logic bad_args;
  assign bad_args = (cmd_r.task_id == '0) || (cmd_r.task_period == '0) ||
                    (cmd_r.compute_ms == '0) || (cmd_r.compute_ms > cmd_r.task_period);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      thresh_r <= rms_pkg::THRESH_RESET;
      used_r <= '0;
      cur_v_r <= 1'b0;
      cur_r <= '0;
      now_r <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_we) thresh_r <= cfg_wdata;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r <= in_word;
            idx_r <= '0;
            hit_r <= 1'b0;
            free_v_r <= 1'b0;
            best_v_r <= 1'b0;
            fired_r <= 1'b0;
            pre_v_r <= 1'b0;
            pre_id_r <= '0;
            status_r <= rms_pkg::ST_OK;
            total_r <= '0;
            if (in_word.mode == rms_pkg::MODE_TICK) now_r <= now_r + 32'd1;
          end
        end
        S_FIND: begin
          if (used_r[ix] && tid_r[ix] == cmd_r.task_id && !hit_r) begin
            hit_r <= 1'b1;
            hit_s_r <= ix;
          end
          if (!used_r[ix] && !free_v_r) begin
            free_v_r <= 1'b1;
            free_s_r <= ix;
          end
          idx_r <= last ? '0 : idx_r + 1'b1;
        end
        S_DIV: begin
          if (ddone) begin
            share_new_r <= dq;
            total_r <= 15'(dq);
          end
        end
        S_SUM: begin
          if (used_r[ix]) total_r <= total_r + 15'(share_r[ix]);
          idx_r <= last ? '0 : idx_r + 1'b1;
        end
        S_CMD: begin
          unique case (cmd_r.mode)
            rms_pkg::MODE_REG: begin
              if (bad_args) status_r <= rms_pkg::ST_INVALID;
              else if (hit_r) status_r <= rms_pkg::ST_DUP;
              else if (total_r > 15'(thresh_r)) status_r <= rms_pkg::ST_OVER;
              else if (!free_v_r) status_r <= rms_pkg::ST_FULL;
              else begin
                used_r[free_s_r] <= 1'b1;
                tid_r[free_s_r] <= cmd_r.task_id;
                per_r[free_s_r] <= cmd_r.task_period;
                share_r[free_s_r] <= share_new_r;
                rs_r[free_s_r] <= rms_pkg::RS_SLEEPING;
                rset_r[free_s_r] <= 1'b0;
                armed_r[free_s_r] <= 1'b0;
              end
            end
            rms_pkg::MODE_DEREG: begin
              if (cmd_r.task_id == '0) status_r <= rms_pkg::ST_INVALID;
              else if (!hit_r) status_r <= rms_pkg::ST_NOTFOUND;
              else begin
                if (cur_v_r && cur_r == hit_s_r) cur_v_r <= 1'b0;
                used_r[hit_s_r] <= 1'b0;
                armed_r[hit_s_r] <= 1'b0;
              end
            end
            default: begin
              // Yield: failures end here, success goes on to dispatch.
              if (cmd_r.task_id == '0) status_r <= rms_pkg::ST_INVALID;
              else if (!hit_r) status_r <= rms_pkg::ST_NOTFOUND;
              else if (rs_r[hit_s_r] != rms_pkg::RS_RUNNING &&
                       rs_r[hit_s_r] != rms_pkg::RS_SLEEPING)
                status_r <= rms_pkg::ST_INVALID;
              else begin
                rs_r[hit_s_r] <= rms_pkg::RS_SLEEPING;
                rel_r[hit_s_r] <= (rset_r[hit_s_r] ? rel_r[hit_s_r] : now_r) +
                                  32'(per_r[hit_s_r]);
                rset_r[hit_s_r] <= 1'b1;
                armed_r[hit_s_r] <= 1'b1;
                fired_r <= 1'b1;
              end
            end
          endcase
        end
        S_TIMER: begin
          if (used_r[ix] && armed_r[ix] && !diff[31]) begin
            armed_r[ix] <= 1'b0;
            if (rs_r[ix] == rms_pkg::RS_SLEEPING) rs_r[ix] <= rms_pkg::RS_READY;
            fired_r <= 1'b1;
          end
          idx_r <= last ? '0 : idx_r + 1'b1;
        end
        S_BEST: begin
          if (used_r[ix] && rs_r[ix] == rms_pkg::RS_READY &&
              (!best_v_r || per_r[ix] < per_r[best_s_r])) begin
            best_v_r <= 1'b1;
            best_s_r <= ix;
          end
          idx_r <= last ? '0 : idx_r + 1'b1;
        end
        S_DISP: begin
          if (fired_r) begin
            if (!cur_v_r) begin
              if (best_v_r) begin
                rs_r[best_s_r] <= rms_pkg::RS_RUNNING;
                cur_r <= best_s_r;
                cur_v_r <= 1'b1;
              end
            end else if (rs_r[cur_r] == rms_pkg::RS_SLEEPING) begin
              if (best_v_r) begin
                rs_r[best_s_r] <= rms_pkg::RS_RUNNING;
                cur_r <= best_s_r;
              end else cur_v_r <= 1'b0;
            end else if (rs_r[cur_r] == rms_pkg::RS_RUNNING) begin
              if (best_v_r && per_r[best_s_r] < per_r[cur_r]) begin
                rs_r[cur_r] <= rms_pkg::RS_READY;
                rs_r[best_s_r] <= rms_pkg::RS_RUNNING;
                pre_v_r <= 1'b1;
                pre_id_r <= tid_r[cur_r];
                cur_r <= best_s_r;
              end
            end
          end
        end
        S_DONE: ;
        default: ;
      endcase
    end
  end

  // The result word is registered from the updated table, together with the output strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) out_strobe <= 1'b0;
    else out_strobe <= strobe_r;
    out_r.status <= status_r;
    out_r.running_valid <= cur_v_r;
    out_r.running_task_id <= cur_v_r ? tid_r[cur_r] : '0;
    out_r.preempted_valid <= pre_v_r;
    out_r.preempted_task_id <= pre_id_r;
    out_r.total_share <= (cmd_r.mode == rms_pkg::MODE_REG && !bad_args && !hit_r) ?
                         total_r : '0;
  end
  assign out_word = out_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy)) else $error("result without a command");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !strobe_r) else $error("strobe while idle");
  a_pre_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.preempted_valid) |-> out_word.running_valid)
    else $error("preemption with nothing running");
endmodule
